// ===== sv/csws_pkg.sv =====
// shared types and constants for the counting semaphore with waiter slots
`timescale 1ns / 1ps
`default_nettype none

package csws_pkg;

    // width of the configuration register index
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INIT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCHED_ON = 1'b1;

    // field widths
    localparam int CMD_W = 2;
    localparam int TASK_W = 8;
    localparam int COUNT_W = 16;
    localparam int WAITERS_W = 4;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_WAIT = 2'd0,
        CMD_SIGNAL = 2'd1,
        CMD_TRY_WAIT = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // flags of one pending result
    typedef struct packed {
        logic acquired;
        logic queued;
        logic wake;
        logic yield_req;
        logic last;
        logic clr;
    } res_flags_t;

    // controller to datapath commands
    typedef struct packed {
        logic       latch_in;
        logic       idx_clr;
        logic       idx_inc;
        logic       cnt_dec;
        logic       cnt_inc;
        logic       take_slot;
        logic       free_slot;
        logic       emit;
        res_flags_t res;
    } dp_ctl_t;

    // datapath to controller status
    typedef struct packed {
        cmd_t cmd;
        logic present;
        logic sched_on;
        logic count_zero;
        logic total_zero;
        logic total_full;
        logic total_one;
        logic used_at_idx;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== sv/csws_ctrl.sv =====
// sequencing controller for the counting semaphore
`timescale 1ns / 1ps
`default_nettype none

module csws_ctrl
    import csws_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire dp_status_t st,
    output dp_ctl_t         ctl
);

    state_t     state_reg;
    state_t     state_next;
    res_flags_t res_reg;
    res_flags_t res_next;
    logic       res_load;
    res_flags_t res_val;

    // state and pending result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            res_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg <= res_next;
        end
    end

    assign res_next = res_load ? res_val : res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                case (st.cmd)
                    CMD_WAIT:
                    begin
                        if (st.sched_on && st.count_zero && st.present && !st.total_full)
                            state_next = ST_SCAN;
                        else
                            state_next = ST_EMIT;
                    end
                    CMD_SIGNAL, CMD_CLEAR:
                    begin
                        if (!st.total_zero)
                            state_next = ST_SCAN;
                        else
                            state_next = ST_EMIT;
                    end
                    default:
                        state_next = ST_EMIT;
                endcase
            end
            ST_SCAN:
            begin
                if (st.cmd == CMD_WAIT)
                begin
                    if (!st.used_at_idx)
                        state_next = ST_EMIT;
                end
                else if (st.used_at_idx)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    if (res_reg.clr && !res_reg.last)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb
    begin
        in_ready = 1'b0;
        ctl = '0;
        res_load = 1'b0;
        res_val = '0;
        res_val.last = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                ctl.latch_in = in_valid;
                ctl.idx_clr = in_valid;
            end
            ST_DECODE:
            begin
                res_load = 1'b1;
                case (st.cmd)
                    CMD_WAIT:
                    begin
                        if (st.sched_on && !st.count_zero)
                        begin
                            ctl.cnt_dec = 1'b1;
                            res_val.acquired = 1'b1;
                        end
                        else if (st.sched_on)
                            res_val.yield_req = 1'b1;
                    end
                    CMD_SIGNAL:
                    begin
                        ctl.cnt_inc = st.total_zero;
                    end
                    CMD_TRY_WAIT:
                    begin
                        ctl.cnt_dec = !st.count_zero;
                        res_val.acquired = !st.count_zero;
                    end
                    CMD_CLEAR:
                    begin
                        res_val.yield_req = st.sched_on;
                    end
                    default:
                        res_load = 1'b0;
                endcase
            end
            ST_SCAN:
            begin
                case (st.cmd)
                    CMD_WAIT:
                    begin
                        // lowest free slot takes the task
                        if (!st.used_at_idx)
                        begin
                            ctl.take_slot = 1'b1;
                            res_load = 1'b1;
                            res_val.queued = 1'b1;
                            res_val.yield_req = 1'b1;
                        end
                        else
                            ctl.idx_inc = 1'b1;
                    end
                    CMD_SIGNAL:
                    begin
                        // lowest occupied slot is woken
                        if (st.used_at_idx)
                        begin
                            ctl.free_slot = 1'b1;
                            res_load = 1'b1;
                            res_val.wake = 1'b1;
                            res_val.yield_req = st.sched_on;
                        end
                        else
                            ctl.idx_inc = 1'b1;
                    end
                    CMD_CLEAR:
                    begin
                        // wake in ascending order, last when the final waiter leaves
                        ctl.idx_inc = 1'b1;
                        if (st.used_at_idx)
                        begin
                            ctl.free_slot = 1'b1;
                            res_load = 1'b1;
                            res_val.wake = 1'b1;
                            res_val.clr = 1'b1;
                            res_val.last = st.total_one;
                            res_val.yield_req = st.sched_on && st.total_one;
                        end
                    end
                    default:
                        ctl.idx_inc = 1'b1;
                endcase
            end
            ST_EMIT:
            begin
                ctl.emit = st.out_free;
            end
            default:
                in_ready = 1'b0;
        endcase
        ctl.res = res_reg;
    end

endmodule

`default_nettype wire

// ===== sv/csws_dp.sv =====
// datapath: count, waiter slot table, task memory and result register
`timescale 1ns / 1ps
`default_nettype none

module csws_dp
    import csws_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [IN_DATA_W-1:0]  in_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire dp_ctl_t               ctl,
    output dp_status_t                 st,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [OUT_DATA_W-1:0]      out_data,
    output logic                       out_last
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TOT_W = $clog2(SLOTS + 1);

    logic               init_wr;
    logic               sched_wr;

    cmd_t               cmd_reg;
    logic               present_reg;
    logic [TASK_W-1:0]  tid_reg;
    logic               sched_reg;
    logic               sched_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [SLOTS-1:0]   used_reg;
    logic [SLOTS-1:0]   used_next;
    logic [TOT_W-1:0]   total_reg;
    logic [TOT_W-1:0]   total_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;

    logic [TASK_W-1:0]  task_mem [SLOTS];
    logic [TASK_W-1:0]  rd_data_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic                  out_last_reg;
    logic                  out_last_next;
    logic [TASK_W-1:0]     wake_task;
    logic [WAITERS_W-1:0]  waiters_now;

    assign init_wr = cfg_we && (cfg_index == REG_INIT_COUNT);
    assign sched_wr = cfg_we && (cfg_index == REG_SCHED_ON);

    // latched request fields
    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            cmd_reg <= cmd_t'(in_data[CMD_W-1:0]);
            present_reg <= in_data[CMD_W];
            tid_reg <= in_data[CMD_W+TASK_W:CMD_W+1];
        end
    end

    // next values of the semaphore state
    always_comb
    begin
        sched_next = sched_wr ? cfg_data[0] : sched_reg;

        count_next = count_reg;
        if (init_wr)
            count_next = cfg_data;
        else if (ctl.cnt_dec)
            count_next = count_reg - 1'b1;
        else if (ctl.cnt_inc && (count_reg != COUNT_MAX))
            count_next = count_reg + 1'b1;

        used_next = used_reg;
        total_next = total_reg;
        if (init_wr)
        begin
            used_next = '0;
            total_next = '0;
        end
        else if (ctl.take_slot)
        begin
            used_next[idx_reg] = 1'b1;
            total_next = total_reg + 1'b1;
        end
        else if (ctl.free_slot)
        begin
            used_next[idx_reg] = 1'b0;
            total_next = total_reg - 1'b1;
        end

        if (ctl.idx_clr)
            idx_next = '0;
        else if (ctl.idx_inc)
            idx_next = idx_reg + 1'b1;
        else
            idx_next = idx_reg;
    end

    // semaphore state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_reg <= 1'b0;
            count_reg <= '0;
            used_reg <= '0;
            total_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            sched_reg <= sched_next;
            count_reg <= count_next;
            used_reg <= used_next;
            total_reg <= total_next;
            idx_reg <= idx_next;
        end
    end

    // task id memory, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.take_slot)
            task_mem[idx_reg] <= tid_reg;
        if (ctl.free_slot)
            rd_data_reg <= task_mem[idx_reg];
    end

    // result fields; clear reports an empty table on every result
    assign wake_task = ctl.res.wake ? rd_data_reg : '0;
    assign waiters_now = ctl.res.clr ? '0 : WAITERS_W'(total_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        if (ctl.emit)
        begin
            out_valid_next = 1'b1;
            out_data_next = {waiters_now, count_reg, ctl.res.yield_req, wake_task,
                             ctl.res.wake, ctl.res.queued, ctl.res.acquired};
            out_last_next = ctl.res.last;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;
    assign out_last = out_last_reg;

    // status to the controller
    always_comb
    begin
        st.cmd = cmd_reg;
        st.present = present_reg;
        st.sched_on = sched_reg;
        st.count_zero = (count_reg == '0);
        st.total_zero = (total_reg == '0);
        st.total_full = (total_reg == TOT_W'(SLOTS));
        st.total_one = (total_reg == TOT_W'(1));
        st.used_at_idx = used_reg[idx_reg];
        st.out_free = !out_valid_reg || out_ready;
    end

    // waiter total always matches the occupied slots
    a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == int'(total_reg))
        else $error("waiter total differs from occupied slot count");

    // no slot is taken while it is used, none freed while it is empty
    a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.take_slot |-> !used_reg[idx_reg]) and (ctl.free_slot |-> used_reg[idx_reg]))
        else $error("slot taken while used or freed while empty");

    // reload of the count empties the table
    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        init_wr |=> (count_reg == $past(cfg_data)) && (total_reg == '0))
        else $error("initial count write did not reload the semaphore");

    // a new result is only loaded into a free output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !ctl.emit)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== sv/counting_semaphore_wait_slots.sv =====
// top level of the counting semaphore with a table of waiter slots
`timescale 1ns / 1ps
`default_nettype none

// Counting semaphore with SLOTS waiter slots. One request is handled at a
// time. Wait that does not queue, try-wait and signal with no waiter present
// their result straight from the decode step, and the next request can be
// accepted once that result is in the output register. Wait that queues a
// task and signal that wakes one scan the slot table one slot per cycle,
// from slot zero, so their result is emitted once the scan reaches the slot
// found. Clear emits one result per waiter, or one for an empty table,
// waking waiters in ascending slot order and resuming the scan after each
// result. A result held in the output register does not block accepting the
// next request, but the result of that request waits in the emit step until
// the output register is free. Writing the starting count register reloads
// the count and empties the table at once.

module counting_semaphore_wait_slots
    import csws_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // request: cmd[1:0], task_present[2], task_id[10:3]
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // result: acquired[0], queued[1], wake_valid[2], wake_task[10:3],
    // yield_req[11], count_now[27:12], waiters_now[31:28]
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    dp_ctl_t    ctl;
    dp_status_t st;

    // sequencing controller
    csws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .ctl      (ctl)
    );

    // datapath
    csws_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl),
        .st        (st),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// self-checking testbench for the counting semaphore with waiter slots
`timescale 1ns / 1ps

module tb;
    import csws_pkg::*;

    localparam int SLOTS = 8;
    // settle time after the last reply, covers a full clear scan
    localparam int SETTLE_CYCLES = 48;
    // long receiver hold-off used to back the block up
    localparam int HOLD_CYCLES = 300;
    // cycles with no handshake on either side before giving up
    localparam int STALL_LIMIT = 4000;

    // one reply as the block reports it
    typedef struct packed {
        logic                  acquired;
        logic                  queued;
        logic                  wake_valid;
        logic [TASK_W-1:0]     wake_task;
        logic                  yield_req;
        logic [COUNT_W-1:0]    count_now;
        logic [WAITERS_W-1:0]  waiters_now;
        logic                  last;
    } sem_reply_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // request: cmd[1:0], task_present[2], task_id[10:3]
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // reply: acquired[0], queued[1], wake_valid[2], wake_task[10:3],
    // yield_req[11], count_now[27:12], waiters_now[31:28]
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // semaphore mirror
    logic [COUNT_W-1:0]     mir_count;
    logic                   mir_sched;
    logic                   mir_used [SLOTS];
    logic [TASK_W-1:0]      mir_task [SLOTS];
    int unsigned            mir_waiters;

    sem_reply_t             sem_replies_due[$];
    int unsigned            error_count = 0;
    int unsigned            quiet_cycles = 0;
    bit                     tx_idle_on = 1'b0;
    bit                     rx_idle_on = 1'b0;
    bit                     hold_replies = 1'b0;

    counting_semaphore_wait_slots #(
        .SLOTS(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // empty the waiter table of the mirror
    task automatic mirror_empty_table();
        for (int i = 0; i < SLOTS; i++)
        begin
            mir_used[i] = 1'b0;
            mir_task[i] = '0;
        end
        mir_waiters = 0;
    endtask

    // apply one accepted request to the mirror and queue the replies it causes
    task automatic apply_sem_command(cmd_t cmd, logic present, logic [TASK_W-1:0] tid);
        sem_reply_t r;
        sem_reply_t batch[$];
        bit         found;
        r = '0;
        r.last = 1'b1;
        found = 1'b0;
        case (cmd)
            CMD_WAIT:
            begin
                if (!mir_sched)
                begin
                    batch.push_back(r);
                end
                else if (mir_count != 0)
                begin
                    mir_count = mir_count - 1'b1;
                    r.acquired = 1'b1;
                    batch.push_back(r);
                end
                else
                begin
                    r.yield_req = 1'b1;
                    if (present && mir_waiters < SLOTS)
                    begin
                        for (int i = 0; i < SLOTS; i++)
                        begin
                            if (!found && !mir_used[i])
                            begin
                                found = 1'b1;
                                mir_used[i] = 1'b1;
                                mir_task[i] = tid;
                                mir_waiters++;
                                r.queued = 1'b1;
                            end
                        end
                    end
                    batch.push_back(r);
                end
            end
            CMD_SIGNAL:
            begin
                if (mir_waiters > 0)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!found && mir_used[i])
                        begin
                            found = 1'b1;
                            r.wake_valid = 1'b1;
                            r.wake_task = mir_task[i];
                            r.yield_req = mir_sched;
                            mir_used[i] = 1'b0;
                            mir_waiters--;
                        end
                    end
                end
                else if (mir_count != COUNT_MAX)
                begin
                    mir_count = mir_count + 1'b1;
                end
                batch.push_back(r);
            end
            CMD_TRY_WAIT:
            begin
                if (mir_count != 0)
                begin
                    mir_count = mir_count - 1'b1;
                    r.acquired = 1'b1;
                end
                batch.push_back(r);
            end
            default:
            begin
                // clear: one wake per occupied slot, lowest slot first
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (mir_used[i])
                    begin
                        r.wake_valid = 1'b1;
                        r.wake_task = mir_task[i];
                        r.last = 1'b0;
                        batch.push_back(r);
                    end
                end
                if (batch.size() == 0)
                begin
                    r.yield_req = mir_sched;
                    batch.push_back(r);
                end
                else
                begin
                    batch[batch.size()-1].last = 1'b1;
                    batch[batch.size()-1].yield_req = mir_sched;
                end
                mirror_empty_table();
            end
        endcase
        // every reply reports the state after the whole command
        foreach (batch[k])
        begin
            batch[k].count_now = mir_count;
            batch[k].waiters_now = WAITERS_W'(mir_waiters);
            sem_replies_due.push_back(batch[k]);
        end
    endtask

    // offer one request, with an optional random gap first
    task automatic send_request(cmd_t cmd, logic present, logic [TASK_W-1:0] tid);
        int unsigned gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 15);
        @(negedge clk);
        if (gap != 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {5'd0, tid, present, cmd};
        do
            @(posedge clk);
        while (!s_axis_tready);
        apply_sem_command(cmd, present, tid);
    endtask

    // stop offering and wait until every reply is in, then let the block settle
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (sem_replies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, only while the block is idle
    task automatic write_sem_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_INIT_COUNT)
        begin
            mir_count = val;
            mirror_empty_table();
        end
        else if (idx == REG_SCHED_ON)
        begin
            mir_sched = val[0];
        end
    endtask

    // random requests, waits weighted by wait_pct
    task automatic send_random(int n, int unsigned wait_pct);
        int unsigned r;
        cmd_t        c;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < wait_pct)
                c = CMD_WAIT;
            else if (r < wait_pct + (100 - wait_pct) * 5 / 10)
                c = CMD_SIGNAL;
            else if (r < wait_pct + (100 - wait_pct) * 8 / 10)
                c = CMD_TRY_WAIT;
            else
                c = CMD_CLEAR;
            send_request(c, $urandom_range(0, 9) != 0, TASK_W'($urandom_range(0, 255)));
        end
    endtask

    // state right after reset: scheduler stopped, count zero
    task automatic test_reset_state();
        send_request(CMD_WAIT, 1'b1, 8'h12);
        send_request(CMD_TRY_WAIT, 1'b1, 8'h00);
        send_request(CMD_CLEAR, 1'b0, 8'hff);
        send_request(CMD_SIGNAL, 1'b0, 8'h00);
        send_request(CMD_TRY_WAIT, 1'b0, 8'h00);
        wait_drained();
    endtask

    // count held at its maximum on signal
    task automatic test_saturation();
        write_sem_reg(REG_INIT_COUNT, COUNT_MAX);
        send_request(CMD_SIGNAL, 1'b1, 8'h01);
        send_request(CMD_TRY_WAIT, 1'b1, 8'h02);
        send_request(CMD_SIGNAL, 1'b0, 8'h03);
        send_request(CMD_SIGNAL, 1'b0, 8'h04);
        wait_drained();
    endtask

    // blocking waits, full table, wake by signal and by clear
    task automatic test_wait_queue();
        write_sem_reg(REG_INIT_COUNT, '0);
        write_sem_reg(REG_SCHED_ON, 1'b1);
        // count zero with no task: yield but nothing queued
        send_request(CMD_WAIT, 1'b0, 8'h77);
        for (int i = 0; i < SLOTS; i++)
            send_request(CMD_WAIT, 1'b1, (i == 0) ? 8'hff : (i == 1) ? 8'h00 : TASK_W'(8'h55 + i));
        // table full: yield, not queued
        send_request(CMD_WAIT, 1'b1, 8'haa);
        send_request(CMD_SIGNAL, 1'b1, 8'h00);
        send_request(CMD_WAIT, 1'b1, 8'h99);
        send_request(CMD_TRY_WAIT, 1'b1, 8'h00);
        send_request(CMD_CLEAR, 1'b1, 8'h00);
        send_request(CMD_CLEAR, 1'b1, 8'h00);
        send_request(CMD_SIGNAL, 1'b1, 8'h00);
        send_request(CMD_WAIT, 1'b1, 8'h33);
        wait_drained();
    endtask

    // random traffic over several register settings
    task automatic test_random_phases();
        logic [COUNT_W-1:0] init_val [6];
        logic               sched_val [6];
        int unsigned        wait_pct [6];
        init_val = '{16'd0, 16'd3, 16'hffff, 16'd0, 16'hfffe, 16'd0};
        sched_val = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        wait_pct = '{45, 50, 35, 40, 10, 55};
        init_val[5] = COUNT_W'($urandom_range(0, 4));
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int p = 0; p < 6; p++)
        begin
            write_sem_reg(REG_INIT_COUNT, init_val[p]);
            write_sem_reg(REG_SCHED_ON, sched_val[p]);
            send_random(70, wait_pct[p]);
            wait_drained();
        end
    endtask

    // receiver holds off while requests keep coming
    task automatic test_backpressure();
        write_sem_reg(REG_INIT_COUNT, 16'd1);
        write_sem_reg(REG_SCHED_ON, 1'b1);
        tx_idle_on = 1'b0;
        hold_replies = 1'b1;
        send_random(30, 45);
        wait_drained();
    endtask

    // back-to-back requests, a pause until drained, then more
    task automatic test_drain_pause();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_sem_reg(REG_INIT_COUNT, '0);
        send_random(20, 50);
        wait_drained();
        send_random(20, 50);
        wait_drained();
    endtask

    // receiver side: random stall bursts and the long hold-off
    initial
    begin
        m_axis_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (hold_replies)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_replies = 1'b0;
                m_axis_tready = 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                m_axis_tready = 1'b1;
            end
        end
    end

    // compare one field of a reply
    task automatic check_field(string name, int unsigned exp_val, int unsigned act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // reply checker
    always @(posedge clk)
    begin
        sem_reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (sem_replies_due.size() == 0)
            begin
                $display("%0t: reply with none pending, expected nothing actual %0h",
                         $time, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = sem_replies_due.pop_front();
                check_field("acquired", want.acquired, m_axis_tdata[0]);
                check_field("queued", want.queued, m_axis_tdata[1]);
                check_field("wake_valid", want.wake_valid, m_axis_tdata[2]);
                check_field("wake_task", want.wake_task, m_axis_tdata[10:3]);
                check_field("yield_req", want.yield_req, m_axis_tdata[11]);
                check_field("count_now", want.count_now, m_axis_tdata[27:12]);
                check_field("waiters_now", want.waiters_now, m_axis_tdata[31:28]);
                check_field("last", want.last, m_axis_tlast);
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = REG_INIT_COUNT;
        cfg_data = '0;
        mir_count = '0;
        mir_sched = 1'b0;
        mirror_empty_table();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_saturation();
        test_wait_queue();
        test_random_phases();
        test_backpressure();
        test_drain_pause();

        if (error_count == 0 && sem_replies_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
